FILE: src/adaptive_bin_histogram_fill_defines.svh
// ============================================================================
// Assertion macros for the adaptive bin histogram fill block
// Each macro checks one implication, in the same cycle or in the next one.
// ============================================================================
`ifndef ADAPTIVE_BIN_HISTOGRAM_FILL_DEFINES_SVH
`define ADAPTIVE_BIN_HISTOGRAM_FILL_DEFINES_SVH
`ifndef SYNTHESIS
`define ABH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ABH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ABH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ABH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: src/abh_pkg.sv
// ============================================================================
// abh_pkg
// Types and constants shared by the adaptive bin histogram fill modules.
// ============================================================================
`timescale 1ns / 1ps

package abh_pkg;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_FILL = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CFG_HALF_BINS = 3'd0,
		CFG_Y_BINS    = 3'd1,
		CFG_Y_MIN     = 3'd2,
		CFG_Y_MAX     = 3'd3,
		CFG_Y_SCALE   = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOCATE,
		ST_ACCESS
	} top_state_t;

	typedef enum logic [1:0] {
		LS_IDLE,
		LS_LAST,
		LS_SCAN,
		LS_ADDR
	} loc_state_t;

	typedef struct packed {
		logic [6:0]         half_bins;
		logic [8:0]         y_bins;
		logic signed [31:0] y_min;
		logic signed [31:0] y_max;
		logic [31:0]        y_scale;
	} cfg_t;

	typedef struct packed {
		logic done;
		logic hit;
	} loc_rsp_t;

	localparam logic [6:0] HALF_BINS_RST = 7'd64;
	localparam logic [8:0] Y_BINS_RST    = 9'd256;

endpackage

FILE: src/abh_ram.sv
// ============================================================================
// abh_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ============================================================================
`timescale 1ns / 1ps

module abh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/abh_locate.sv
// ============================================================================
// abh_locate
// Bin locator: walks the boundary table one entry per cycle to find the x
// bin, scales y to its linear bin and forms the histogram address.
// ============================================================================
`timescale 1ns / 1ps

module abh_locate #(
	parameter int MAX_HALF_BINS = 64,
	parameter int MAX_Y_BINS = 256,
	localparam int KAW = $clog2(MAX_HALF_BINS),
	localparam int HAW = $clog2((2 * MAX_HALF_BINS + 2) * (MAX_Y_BINS + 2))
) (
	input  logic               clk,
	input  logic               arst_n,
	input  abh_pkg::cfg_t      cfg,
	input  logic               start,
	input  logic signed [31:0] x,
	input  logic signed [31:0] y,
	input  logic               kw_en,
	input  logic [KAW-1:0]     kw_addr,
	input  logic [31:0]        kw_data,
	output abh_pkg::loc_rsp_t  rsp,
	output logic [HAW-1:0]     addr
);

	import abh_pkg::*;

	localparam int HW   = $clog2(MAX_HALF_BINS + 1);
	localparam int CMPW = (HW > 7) ? HW : 7;
	localparam int NYW  = $clog2(MAX_Y_BINS + 1);
	localparam int CMPY = (NYW > 9) ? NYW : 9;
	localparam int XW   = $clog2(2 * MAX_HALF_BINS + 1);
	localparam int RW   = $clog2(2 * MAX_HALF_BINS + 3);
	localparam int YBW  = $clog2(MAX_Y_BINS + 2);

	loc_state_t state_q, state_d;

	logic [CMPW-1:0]    h_w;
	logic [HW-1:0]      h_eff;
	logic [HW-1:0]      h_m1;
	logic [CMPY-1:0]    ny_w;
	logic [NYW-1:0]     ny_eff;
	logic [32:0]        a_in;
	logic [32:0]        a_q;
	logic               xneg_q;
	logic [31:0]        ydiff_q;
	logic [63:0]        prod_q;
	logic [KAW-1:0]     cnt_q;
	logic               prev_le_q;
	logic [YBW-1:0]     ybin_q;
	logic [XW-1:0]      xbin_q;
	logic [HAW-1:0]     addr_q;
	logic               done_q;
	logic               hit_q;
	logic [31:0]        t_data;
	logic signed [33:0] a_s;
	logic signed [33:0] t_s;
	logic               le;
	logic [KAW-1:0]     rd_addr;
	logic               cap;
	logic               mul_en;
	logic               cnt_clr;
	logic               cnt_inc;
	logic               xbin_ld;
	logic               found;
	logic               addr_ld;
	logic               fin;
	logic               fin_hit;
	logic [KAW-1:0]     b_sel;
	logic [XW-1:0]      xbin_d;
	logic [47:0]        off;
	logic [NYW-1:0]     off_sat;
	logic [YBW-1:0]     ybin_d;
	logic [RW-1:0]      row;
	logic [YBW+RW-1:0]  yrow;
	logic [HAW-1:0]     addr_d;

	assign h_w    = (CMPW'(cfg.half_bins) > CMPW'(MAX_HALF_BINS)) ?
		CMPW'(MAX_HALF_BINS) : CMPW'(cfg.half_bins);
	assign h_eff  = HW'(h_w);
	assign h_m1   = h_eff - HW'(1);
	assign ny_w   = (CMPY'(cfg.y_bins) > CMPY'(MAX_Y_BINS)) ?
		CMPY'(MAX_Y_BINS) : CMPY'(cfg.y_bins);
	assign ny_eff = NYW'(ny_w);

	assign a_in = x[31] ? (33'd0 - {x[31], x}) : {1'b0, x};
	assign a_s  = signed'({1'b0, a_q});
	assign t_s  = signed'({{2{t_data[31]}}, t_data});
	assign le   = (a_s <= t_s);

	assign b_sel  = found ? (cnt_q - KAW'(1)) : cnt_q;
	assign xbin_d = xneg_q ? (XW'(b_sel) + XW'(1)) : ((XW'(h_eff) << 1) - XW'(b_sel));

	assign off     = prod_q[63:16];
	assign off_sat = (off > 48'(ny_eff)) ? ny_eff : off[NYW-1:0];
	assign ybin_d  = YBW'(off_sat) + YBW'(1);
	assign row     = (RW'(h_eff) << 1) + RW'(2);
	assign yrow    = (YBW+RW)'(ybin_q) * (YBW+RW)'(row);
	assign addr_d  = HAW'(xbin_q) + HAW'(yrow);

	abh_ram #(
		.WIDTH (32),
		.DEPTH (MAX_HALF_BINS)
	) u_kappa_ram (
		.clk   (clk),
		.we    (kw_en),
		.waddr (kw_addr),
		.wdata (kw_data),
		.re    (1'b1),
		.raddr (rd_addr),
		.rdata (t_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LS_IDLE;
			done_q  <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			hit_q   <= fin_hit;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_addr = cnt_q + KAW'(1);
		cap     = 1'b0;
		mul_en  = 1'b0;
		cnt_clr = 1'b0;
		cnt_inc = 1'b0;
		xbin_ld = 1'b0;
		found   = 1'b0;
		addr_ld = 1'b0;
		fin     = 1'b0;
		fin_hit = 1'b0;
		case (state_q)
			LS_IDLE: begin
				rd_addr = h_m1[KAW-1:0];
				if (start) begin
					if (h_eff == '0 || y < cfg.y_min || y > cfg.y_max) begin
						fin = 1'b1;
					end else begin
						cap     = 1'b1;
						state_d = LS_LAST;
					end
				end
			end
			LS_LAST: begin
				rd_addr = '0;
				if (a_s < t_s) begin
					fin     = 1'b1;
					state_d = LS_IDLE;
				end else begin
					mul_en  = 1'b1;
					cnt_clr = 1'b1;
					state_d = LS_SCAN;
				end
			end
			LS_SCAN: begin
				if (cnt_q == '0 && !le) begin
					fin     = 1'b1;
					state_d = LS_IDLE;
				end else if (cnt_q != '0 && prev_le_q && !le) begin
					found   = 1'b1;
					xbin_ld = 1'b1;
					state_d = LS_ADDR;
				end else if (HW'(cnt_q) == h_m1) begin
					xbin_ld = 1'b1;
					state_d = LS_ADDR;
				end else begin
					cnt_inc = 1'b1;
				end
			end
			LS_ADDR: begin
				addr_ld = 1'b1;
				fin     = 1'b1;
				fin_hit = 1'b1;
				state_d = LS_IDLE;
			end
			default: begin
				state_d = LS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			a_q     <= a_in;
			xneg_q  <= x[31];
			ydiff_q <= y - cfg.y_min;
		end
		if (mul_en) begin
			prod_q <= 64'(ydiff_q) * 64'(cfg.y_scale);
		end
		if (cnt_clr) begin
			cnt_q <= '0;
		end else if (cnt_inc) begin
			cnt_q     <= cnt_q + KAW'(1);
			prev_le_q <= le;
		end
		if (state_q == LS_SCAN) begin
			ybin_q <= ybin_d;
		end
		if (xbin_ld) begin
			xbin_q <= xbin_d;
		end
		if (addr_ld) begin
			addr_q <= addr_d;
		end
	end

	assign rsp.done = done_q;
	assign rsp.hit  = hit_q;
	assign addr     = addr_q;

endmodule

FILE: src/adaptive_bin_histogram_fill.sv
// ============================================================================
// adaptive_bin_histogram_fill
// Fill: the result strobe follows the boundary search, which reads one table
// entry per cycle, and on a hit the histogram read-modify-write in ST_ACCESS.
// Read: histogram read, then ST_ACCESS; out-of-range reads and loads answer
// from ST_IDLE. A new transfer can be taken at the edge that takes the
// previous result. After reset the histogram RAM is cleared one entry per
// cycle with busy high; results are one-cycle strobes.
// ============================================================================
`timescale 1ns / 1ps
`include "adaptive_bin_histogram_fill_defines.svh"

module adaptive_bin_histogram_fill #(
	parameter int MAX_HALF_BINS = 64,
	parameter int MAX_Y_BINS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] value,
	input  logic signed [31:0] angle,
	input  logic [15:0]        weight,
	input  logic [15:0]        index,
	output logic               done,
	output logic               accepted,
	output logic [15:0]        bin_address,
	output logic [31:0]        content
);

	import abh_pkg::*;

	localparam int HIST_DEPTH = (2 * MAX_HALF_BINS + 2) * (MAX_Y_BINS + 2);
	localparam int HAW = $clog2(HIST_DEPTH);
	localparam int KAW = $clog2(MAX_HALF_BINS);

	top_state_t state_q, state_d;
	cfg_t       cfg_q;
	loc_rsp_t   loc_rsp;

	logic [HAW-1:0] loc_addr;
	logic [HAW-1:0] clr_cnt_q;
	logic           clr_inc;
	logic [HAW-1:0] acc_addr_q;
	logic           is_fill_q;
	logic [15:0]    weight_q;
	logic           take;
	logic           loc_start;
	logic           kw_en;
	logic           hist_we;
	logic [HAW-1:0] hist_waddr;
	logic [31:0]    hist_wdata;
	logic           hist_re;
	logic [HAW-1:0] hist_raddr;
	logic [31:0]    hist_rdata;
	logic [31:0]    sum;
	logic           acc_ld;
	logic           res_ld;
	logic           res_acc;
	logic [15:0]    res_addr;
	logic [31:0]    res_content;
	logic           done_q;
	logic           accepted_q;
	logic [15:0]    bin_address_q;
	logic [31:0]    content_q;

	assign busy = (state_q != ST_IDLE);
	assign take = start && !busy;
	assign sum  = hist_rdata + 32'(weight_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_bins <= HALF_BINS_RST;
			cfg_q.y_bins    <= Y_BINS_RST;
			cfg_q.y_min     <= '0;
			cfg_q.y_max     <= '0;
			cfg_q.y_scale   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HALF_BINS: cfg_q.half_bins <= cfg_data[6:0];
				CFG_Y_BINS:    cfg_q.y_bins    <= cfg_data[8:0];
				CFG_Y_MIN:     cfg_q.y_min     <= signed'(cfg_data);
				CFG_Y_MAX:     cfg_q.y_max     <= signed'(cfg_data);
				CFG_Y_SCALE:   cfg_q.y_scale   <= cfg_data;
				default: ;
			endcase
		end
	end

	abh_locate #(
		.MAX_HALF_BINS (MAX_HALF_BINS),
		.MAX_Y_BINS    (MAX_Y_BINS)
	) u_locate (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.start   (loc_start),
		.x       (value),
		.y       (angle),
		.kw_en   (kw_en),
		.kw_addr (index[KAW-1:0]),
		.kw_data (value),
		.rsp     (loc_rsp),
		.addr    (loc_addr)
	);

	abh_ram #(
		.WIDTH (32),
		.DEPTH (HIST_DEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (hist_re),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_ld;
			if (clr_inc) begin
				clr_cnt_q <= clr_cnt_q + HAW'(1);
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		clr_inc     = 1'b0;
		loc_start   = 1'b0;
		kw_en       = 1'b0;
		hist_we     = 1'b0;
		hist_waddr  = clr_cnt_q;
		hist_wdata  = '0;
		hist_re     = 1'b0;
		hist_raddr  = loc_addr;
		acc_ld      = 1'b0;
		res_ld      = 1'b0;
		res_acc     = 1'b0;
		res_addr    = '0;
		res_content = '0;
		case (state_q)
			ST_CLEAR: begin
				hist_we = 1'b1;
				if (clr_cnt_q == HAW'(HIST_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end else begin
					clr_inc = 1'b1;
				end
			end
			ST_IDLE: begin
				if (take) begin
					case (opcode)
						OP_LOAD: begin
							res_ld = 1'b1;
							if (32'(index) < 32'(MAX_HALF_BINS)) begin
								kw_en       = 1'b1;
								res_acc     = 1'b1;
								res_content = value;
							end
						end
						OP_FILL: begin
							loc_start = 1'b1;
							state_d   = ST_LOCATE;
						end
						OP_READ: begin
							if (32'(index) < 32'(HIST_DEPTH)) begin
								hist_re    = 1'b1;
								hist_raddr = HAW'(index);
								acc_ld     = 1'b1;
								state_d    = ST_ACCESS;
							end else begin
								res_ld   = 1'b1;
								res_addr = index;
							end
						end
						default: begin
							res_ld = 1'b1;
						end
					endcase
				end
			end
			ST_LOCATE: begin
				if (loc_rsp.done) begin
					if (loc_rsp.hit) begin
						hist_re = 1'b1;
						acc_ld  = 1'b1;
						state_d = ST_ACCESS;
					end else begin
						res_ld  = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_ACCESS: begin
				res_ld   = 1'b1;
				res_acc  = 1'b1;
				res_addr = 16'(acc_addr_q);
				if (is_fill_q) begin
					hist_we     = 1'b1;
					hist_waddr  = acc_addr_q;
					hist_wdata  = sum;
					res_content = sum;
				end else begin
					res_content = hist_rdata;
				end
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			weight_q <= weight;
		end
		if (acc_ld) begin
			acc_addr_q <= hist_raddr;
			is_fill_q  <= (state_q == ST_LOCATE);
		end
		if (res_ld) begin
			accepted_q    <= res_acc;
			bin_address_q <= res_addr;
			content_q     <= res_content;
		end
	end

	assign done        = done_q;
	assign accepted    = accepted_q;
	assign bin_address = bin_address_q;
	assign content     = content_q;

	`ABH_ASSERT_NEXT(a_take_progress, clk, arst_n, take, busy || done, "accepted transfer lost")
	`ABH_ASSERT_SAME(a_loc_done, clk, arst_n, loc_rsp.done, state_q == ST_LOCATE, "stray locate done")
	`ABH_ASSERT_SAME(a_reject_zero, clk, arst_n, done && !accepted, content == '0, "reject with content")

endmodule
